[sv/mahs_pkg.sv]
package mahs_pkg;

    localparam int POSITION_BITS_DEF = 16;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = 1;
    localparam int QUEUE_CNT_BITS  = 2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TEMPLATE_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TEMPLATE_RATE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_SEARCH      = 2'd2;

    localparam logic [15:0] MAX_SEARCH_RESET = 16'd4096;
    localparam logic [15:0] MIN_SEARCH       = 16'd5;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [3:0] SYNC_NIBBLE = 4'hF;

    localparam logic [1:0] VER_MPEG1 = 2'd1;
    localparam logic [1:0] VER_MPEG2 = 2'd2;

    localparam logic [1:0] LAYER_I   = 2'd1;
    localparam logic [1:0] LAYER_II  = 2'd2;
    localparam logic [1:0] LAYER_III = 2'd3;

    localparam logic [10:0] SAMPLES_L1       = 11'd384;
    localparam logic [10:0] SAMPLES_MPEG2_L3 = 11'd576;
    localparam logic [10:0] SAMPLES_FULL     = 11'd1152;

    localparam logic [17:0] COEFF_L1       = 18'd12000;
    localparam logic [17:0] COEFF_MPEG2_L3 = 18'd72000;
    localparam logic [17:0] COEFF_FULL     = 18'd144000;

    localparam int QUOT_BITS = 11;
    localparam int PROD_BITS = 27;

    // [mpeg2][layer-1][index]; layer row 3 stands for the reserved layer code
    localparam logic [8:0] KBPS_TABLE [2][4][16] = '{
        '{
            '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
            '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
            '{default: 9'd0}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{default: 9'd0}
        }
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic [1:0]  version_level;
        logic [1:0]  layer;
        logic        protect_bit;
        logic        padding_bit;
        logic [1:0]  channel_mode;
        logic [15:0] sample_rate;
        logic [8:0]  bitrate_kbps;
        logic [10:0] frame_bytes;
        logic [10:0] frame_samples;
    } out_item_t;

    typedef struct packed {
        logic        template_enable;
        logic [15:0] template_rate;
        logic [15:0] max_search;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    function automatic logic [15:0] rate_lookup(input logic mpeg1, input logic [1:0] fidx);
        logic [15:0] r;
        begin
            case (fidx)
                2'd0:    r = mpeg1 ? 16'd44100 : 16'd22050;
                2'd1:    r = mpeg1 ? 16'd48000 : 16'd24000;
                2'd2:    r = mpeg1 ? 16'd32000 : 16'd16000;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [8:0] kbps_lookup(input logic mpeg1, input logic [1:0] layer,
                                               input logic [3:0] bidx);
        logic [1:0] row;
        begin
            row = 2'(layer - 2'd1);
            return KBPS_TABLE[!mpeg1][row][bidx];
        end
    endfunction

    function automatic logic [17:0] frame_coeff(input logic [1:0] version,
                                                input logic [1:0] layer);
        logic [17:0] c;
        begin
            if (layer == LAYER_I)
                c = COEFF_L1;
            else if (layer == LAYER_III && version == VER_MPEG2)
                c = COEFF_MPEG2_L3;
            else
                c = COEFF_FULL;
            return c;
        end
    endfunction

endpackage

[sv/mahs_front.sv]
module mahs_front #(
    parameter int POSITION_BITS = mahs_pkg::POSITION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  mahs_pkg::in_item_t  item,
    input  mahs_pkg::cfg_t      cfg,
    output logic                push,
    output mahs_pkg::out_item_t entry
);

    localparam int CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;

    logic [23:0]              win_reg, win_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     done_reg, done_next;

    logic [23:0]              win_eff;
    logic [POSITION_BITS-1:0] pos_eff;
    logic                     done_eff;
    logic [7:0]               b0, b1, b2, b3;
    logic                     mpeg1;
    logic [1:0]               lay;
    logic [15:0]              sr;
    logic [8:0]               br;
    logic                     hdr_ok;
    logic                     tiny;
    logic                     at_end;
    logic [POSITION_BITS-1:0] start;
    logic [10:0]              samples;
    mahs_pkg::out_item_t      hit;

    always_comb
    begin
        win_eff  = item.first_byte ? 24'd0 : win_reg;
        pos_eff  = item.first_byte ? '0 : pos_reg;
        done_eff = item.first_byte ? 1'b0 : done_reg;

        b0 = win_eff[23:16];
        b1 = win_eff[15:8];
        b2 = win_eff[7:0];
        b3 = item.data_byte;

        mpeg1 = b1[3];
        lay   = 2'(3'd4 - {1'b0, b1[2:1]});
        sr    = mahs_pkg::rate_lookup(mpeg1, b2[3:2]);
        br    = mahs_pkg::kbps_lookup(mpeg1, lay, b2[7:4]);

        hdr_ok = (b0 == mahs_pkg::SYNC_BYTE) && (b1[7:4] == mahs_pkg::SYNC_NIBBLE)
                 && (lay != 2'd0) && (sr != 16'd0) && (br != 9'd0)
                 && !(cfg.template_enable && (cfg.template_rate != sr))
                 && (pos_eff >= POSITION_BITS'(3));

        tiny   = cfg.max_search < mahs_pkg::MIN_SEARCH;
        at_end = (CW'(pos_eff) + CW'(2)) >= CW'(cfg.max_search);
        start  = pos_eff - POSITION_BITS'(3);

        if (lay == mahs_pkg::LAYER_I)
            samples = mahs_pkg::SAMPLES_L1;
        else if (lay == mahs_pkg::LAYER_III && !mpeg1)
            samples = mahs_pkg::SAMPLES_MPEG2_L3;
        else
            samples = mahs_pkg::SAMPLES_FULL;

        hit               = '0;
        hit.found         = 1'b1;
        hit.offset        = 16'(start);
        hit.version_level = mpeg1 ? mahs_pkg::VER_MPEG1 : mahs_pkg::VER_MPEG2;
        hit.layer         = lay;
        hit.protect_bit   = b1[0];
        hit.padding_bit   = b2[1];
        hit.channel_mode  = b3[7:6];
        hit.sample_rate   = sr;
        hit.bitrate_kbps  = br;
        hit.frame_samples = samples;

        win_next  = win_reg;
        pos_next  = pos_reg;
        done_next = done_reg;
        push      = 1'b0;
        entry     = '0;

        if (accept && !done_eff)
        begin
            win_next  = win_eff;
            pos_next  = pos_eff;
            done_next = 1'b1;
            push      = 1'b1;
            if (tiny)
            begin
                entry = '0;
            end
            else if (hdr_ok)
            begin
                entry = hit;
            end
            else
            begin
                win_next  = {win_eff[15:0], b3};
                pos_next  = pos_eff + POSITION_BITS'(1);
                done_next = at_end;
                push      = at_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            pos_reg  <= '0;
            done_reg <= 1'b1;
        end
        else
        begin
            win_reg  <= win_next;
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

endmodule

[sv/mahs_queue.sv]
module mahs_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mahs_pkg::out_item_t     push_data,
    input  logic                    pop,
    output mahs_pkg::out_item_t     pop_data,
    output mahs_pkg::queue_status_t status
);

    mahs_pkg::out_item_t                   slot_reg [mahs_pkg::QUEUE_DEPTH];
    logic [mahs_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mahs_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mahs_pkg::QUEUE_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                                  do_push, do_pop;

    always_comb
    begin
        status.empty = (cnt_reg == '0);
        status.full  = (cnt_reg == mahs_pkg::QUEUE_CNT_BITS'(mahs_pkg::QUEUE_DEPTH));
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        pop_data     = slot_reg[rd_ptr_reg];
        wr_ptr_next  = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next     = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[sv/mahs_back.sv]
module mahs_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mahs_pkg::queue_status_t q_status,
    input  mahs_pkg::out_item_t     q_data,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output mahs_pkg::out_item_t     out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    localparam int QB       = mahs_pkg::QUOT_BITS;
    localparam int CNT_BITS = $clog2(QB);

    logic [1:0]          state_reg, state_next;
    mahs_pkg::out_item_t entry_reg, entry_next;
    logic [15:0]         rem_reg, rem_next;
    logic [QB-1:0]       quo_reg, quo_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    mahs_pkg::out_item_t out_data_reg, out_data_next;

    logic [mahs_pkg::PROD_BITS-1:0] product;
    logic [16:0]                    trial;
    logic                           qbit;
    logic [QB-1:0]                  quo_pad;
    logic [QB-1:0]                  frame;

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        product = mahs_pkg::PROD_BITS'(mahs_pkg::frame_coeff(entry_reg.version_level,
                                                             entry_reg.layer))
                  * mahs_pkg::PROD_BITS'(entry_reg.bitrate_kbps);
        trial   = {rem_reg, quo_reg[QB-1]};
        qbit    = trial >= {1'b0, entry_reg.sample_rate};
        quo_pad = quo_reg + QB'(entry_reg.padding_bit);
        if (!entry_reg.found)
            frame = '0;
        else if (entry_reg.layer == mahs_pkg::LAYER_I)
            frame = QB'({quo_pad, 2'b00});
        else
            frame = quo_pad;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    entry_next = q_data;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                rem_next   = 16'(product[mahs_pkg::PROD_BITS-2:QB]);
                quo_next   = product[QB-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = qbit ? 16'(trial - {1'b0, entry_reg.sample_rate}) : trial[15:0];
                quo_next = {quo_reg[QB-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QB - 1))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = entry_reg;
                    out_data_next.frame_bytes = frame;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/mpeg_audio_header_scanner_unit.sv]
// MPEG-1/2 audio frame header scanner. Bytes enter one per cycle; first_byte starts a new
// search at position zero. Each search yields at most one result: the first valid header
// (found=1, decoded fields, offset of the sync byte, frame length and samples) or found=0
// with all other fields zero once the window of max_search bytes is used up. Input is
// stalled only while the two-entry result queue is full. Each result then passes through
// the frame length unit (queue pop, one multiply, 11 restoring divide steps, output load)
// before it is presented.
// Configuration writes take effect on the next byte and are meant for idle periods.
module mpeg_audio_header_scanner_unit #(
    parameter int POSITION_BITS = mahs_pkg::POSITION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  mahs_pkg::in_item_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output mahs_pkg::out_item_t                   out_data,
    input  logic                                  cfg_wr_en,
    input  logic [mahs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mahs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    mahs_pkg::cfg_t          cfg_reg, cfg_next;
    mahs_pkg::queue_status_t q_status;
    mahs_pkg::out_item_t     q_push_data;
    mahs_pkg::out_item_t     q_pop_data;
    logic                    q_push;
    logic                    q_pop;
    logic                    in_accept;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mahs_pkg::REG_TEMPLATE_ENABLE: cfg_next.template_enable = cfg_data[0];
                mahs_pkg::REG_TEMPLATE_RATE:   cfg_next.template_rate   = cfg_data;
                mahs_pkg::REG_MAX_SEARCH:      cfg_next.max_search      = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.template_enable <= 1'b0;
            cfg_reg.template_rate   <= 16'd0;
            cfg_reg.max_search      <= mahs_pkg::MAX_SEARCH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_stall  = q_status.full;
    assign in_accept = in_valid && !in_stall;

    mahs_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .push   (q_push),
        .entry  (q_push_data)
    );

    mahs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    mahs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_pop_data),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_push)
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> !q_pop)
        else $error("result queue read while empty");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.found) |->
            (out_data.frame_bytes == 11'd0 && out_data.sample_rate == 16'd0
             && out_data.offset == 16'd0))
        else $error("not-found transaction carries nonzero fields");

    a_found_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.found) |-> (out_data.frame_bytes != 11'd0))
        else $error("found transaction with zero frame length");
`endif

endmodule

[dv/mpeg_audio_header_scanner_unit_test.sv]
`timescale 1ns / 100ps

module mpeg_audio_header_scanner_unit_test;

    localparam int RANDOM_BYTES  = 1850;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 120;

    localparam int unsigned MPEG1_RATE [4] = '{44100, 48000, 32000, 0};
    localparam int unsigned MPEG2_RATE [4] = '{22050, 24000, 16000, 0};
    localparam int unsigned TEMPLATE_CHOICES [7] = '{0, 16000, 22050, 24000, 32000, 44100, 48000};

    // [mpeg2][layer-1][index], kbit/s
    localparam int unsigned KBPS [2][3][16] = '{
        '{
            '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
            '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
        },
        '{
            '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
            '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
        }
    };

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    mahs_pkg::in_item_t                  in_data = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b1;
    mahs_pkg::out_item_t                 out_data;
    logic                                cfg_wr_en = 1'b0;
    logic [mahs_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [mahs_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // scanner state as the testbench tracks it
    logic        tmpl_en = 1'b0;
    logic [15:0] tmpl_rate = '0;
    logic [15:0] search_len = mahs_pkg::MAX_SEARCH_RESET;
    logic [23:0] scan_window = '0;
    logic [15:0] scan_pos = '0;
    logic        scan_done = 1'b1;

    mahs_pkg::out_item_t awaited_results [$];
    int                  error_count = 0;
    int                  result_count = 0;
    int                  sent_bytes = 0;
    int                  stall_hold_cycles = 0;
    bit                  idle_on = 1'b1;

    mpeg_audio_header_scanner_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit decode_header(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [15:0] start,
                                         output mahs_pkg::out_item_t hdr);
        int unsigned ver;
        int unsigned lay;
        int unsigned sr;
        int unsigned br;
        int unsigned pad;
        int unsigned nbytes;
        int unsigned nsamples;
        hdr = '0;
        if (b0 != mahs_pkg::SYNC_BYTE || b1[7:4] != mahs_pkg::SYNC_NIBBLE)
            return 1'b0;
        ver = b1[3] ? 1 : 2;
        lay = (4 - b1[2:1]) & 3;
        if (lay == 0)
            return 1'b0;
        sr = (ver == 1) ? MPEG1_RATE[b2[3:2]] : MPEG2_RATE[b2[3:2]];
        if (sr == 0)
            return 1'b0;
        br = KBPS[ver - 1][lay - 1][b2[7:4]];
        if (br == 0)
            return 1'b0;
        if (tmpl_en && tmpl_rate != sr)
            return 1'b0;
        pad = b2[1];
        if (lay == mahs_pkg::LAYER_I)
        begin
            nsamples = mahs_pkg::SAMPLES_L1;
            nbytes = ((12000 * br) / sr + pad) * 4;
        end
        else if (lay == mahs_pkg::LAYER_III && ver == mahs_pkg::VER_MPEG2)
        begin
            nsamples = mahs_pkg::SAMPLES_MPEG2_L3;
            nbytes = (72000 * br) / sr + pad;
        end
        else
        begin
            nsamples = mahs_pkg::SAMPLES_FULL;
            nbytes = (144000 * br) / sr + pad;
        end
        hdr.found         = 1'b1;
        hdr.offset        = start;
        hdr.version_level = ver[1:0];
        hdr.layer         = lay[1:0];
        hdr.protect_bit   = b1[0];
        hdr.padding_bit   = b2[1];
        hdr.channel_mode  = b3[7:6];
        hdr.sample_rate   = sr[15:0];
        hdr.bitrate_kbps  = br[8:0];
        hdr.frame_bytes   = nbytes[10:0];
        hdr.frame_samples = nsamples[10:0];
        return 1'b1;
    endfunction

    // advances the tracked scanner by one byte; returns 1 when the byte yields a result
    function automatic bit scan_step(input mahs_pkg::in_item_t item,
                                     output mahs_pkg::out_item_t res);
        logic [15:0] p;
        res = '0;
        if (item.first_byte)
        begin
            scan_pos = '0;
            scan_window = '0;
            scan_done = 1'b0;
        end
        if (scan_done)
            return 1'b0;
        p = scan_pos;
        if (search_len < mahs_pkg::MIN_SEARCH)
        begin
            scan_done = 1'b1;
            return 1'b1;
        end
        if (p >= 16'd3 && decode_header(scan_window[23:16], scan_window[15:8], scan_window[7:0],
                                        item.data_byte, p - 16'd3, res))
        begin
            scan_done = 1'b1;
            return 1'b1;
        end
        res = '0;
        scan_window = {scan_window[15:0], item.data_byte};
        scan_pos = p + 16'd1;
        if (int'(p) + 2 >= int'(search_len))
        begin
            scan_done = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: result %0d: %s", $time, result_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        mahs_pkg::out_item_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = awaited_results.pop_front();
                check_field("found", out_data.found, want.found);
                check_field("offset", out_data.offset, want.offset);
                check_field("version_level", out_data.version_level, want.version_level);
                check_field("layer", out_data.layer, want.layer);
                check_field("protect_bit", out_data.protect_bit, want.protect_bit);
                check_field("padding_bit", out_data.padding_bit, want.padding_bit);
                check_field("channel_mode", out_data.channel_mode, want.channel_mode);
                check_field("sample_rate", out_data.sample_rate, want.sample_rate);
                check_field("bitrate_kbps", out_data.bitrate_kbps, want.bitrate_kbps);
                check_field("frame_bytes", out_data.frame_bytes, want.frame_bytes);
                check_field("frame_samples", out_data.frame_samples, want.frame_samples);
            end
            result_count++;
        end
    end

    initial
    begin : result_receiver
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                wait_left = idle_on ? $urandom_range(0, 3) : 0;
            if (stall_hold_cycles > 0)
            begin
                stall_hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic first);
        mahs_pkg::in_item_t  item;
        mahs_pkg::out_item_t res;
        int                  gap;
        item.data_byte = value;
        item.first_byte = first;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sent_bytes++;
        if (scan_step(item, res))
            awaited_results.push_back(res);
    endtask

    task automatic send_header(input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] b3);
        send_byte(mahs_pkg::SYNC_BYTE, 1'b0);
        send_byte(b1, 1'b0);
        send_byte(b2, 1'b0);
        send_byte(b3, 1'b0);
    endtask

    task automatic wait_drained();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (awaited_results.size() > 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_results.size() > 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
            awaited_results.delete();
        end
    endtask

    task automatic write_reg(input logic [mahs_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [mahs_pkg::CFG_DATA_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            mahs_pkg::REG_TEMPLATE_ENABLE: tmpl_en = value[0];
            mahs_pkg::REG_TEMPLATE_RATE:   tmpl_rate = value;
            mahs_pkg::REG_MAX_SEARCH:      search_len = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic en, input logic [15:0] rate,
                              input logic [15:0] window);
        write_reg(mahs_pkg::REG_TEMPLATE_ENABLE, 16'(en));
        write_reg(mahs_pkg::REG_TEMPLATE_RATE, rate);
        write_reg(mahs_pkg::REG_MAX_SEARCH, window);
    endtask

    // one search: noise with false syncs, optionally a planted header
    task automatic run_search(input int len, input bit need_header, input bit well_formed);
        logic [7:0] stream [$];
        int         at;
        for (int i = 0; i < len; i++)
            stream.push_back(($urandom_range(0, 3) == 0) ? mahs_pkg::SYNC_BYTE : 8'($urandom));
        if (need_header && len >= 4)
        begin
            at = $urandom_range(0, len - 4);
            stream[at] = mahs_pkg::SYNC_BYTE;
            if (well_formed)
            begin
                stream[at + 1] = {mahs_pkg::SYNC_NIBBLE, 1'($urandom),
                                  2'($urandom_range(1, 3)), 1'($urandom)};
                stream[at + 2] = {4'($urandom_range(1, 14)), 2'($urandom_range(0, 2)),
                                  2'($urandom)};
            end
            else
            begin
                stream[at + 1] = {mahs_pkg::SYNC_NIBBLE, 4'($urandom)};
                stream[at + 2] = 8'($urandom);
            end
            stream[at + 3] = 8'($urandom);
        end
        foreach (stream[i])
            send_byte(stream[i], i == 0);
    endtask

    task automatic test_idle_after_reset();
        // registers still at reset values
        send_byte(8'h12, 1'b0);
        send_byte(mahs_pkg::SYNC_BYTE, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hC4, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_drained();
    endtask

    task automatic test_tiny_window();
        write_reg(mahs_pkg::REG_MAX_SEARCH, 16'd0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
        write_reg(mahs_pkg::REG_MAX_SEARCH, 16'd4);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_window_exhausted();
        write_reg(mahs_pkg::REG_MAX_SEARCH, mahs_pkg::MIN_SEARCH);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'h90, 1'b0);
        wait_drained();
    endtask

    task automatic test_header_rejects();
        set_config(1'b1, 16'd48000, 16'd65535);
        send_byte(8'h00, 1'b1);
        send_header(8'hF1, 8'h00, 8'h00);
        send_header(8'hFF, 8'h0C, 8'h00);
        send_header(8'hFB, 8'h90, 8'h00);
        send_header(8'hFF, 8'hE6, 8'hC0);
        wait_drained();
    endtask

    task automatic test_input_backpressure();
        set_config(1'b0, 16'd0, 16'd2);
        idle_on = 1'b0;
        stall_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom), 1'b1);
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_streams();
        int          sel;
        int          window;
        int          len;
        int          searches;
        logic        en;
        logic [15:0] rate;
        while (sent_bytes < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 11);
            if (sel == 0)
                window = 5;
            else if (sel == 10)
                window = $urandom_range(0, 4);
            else if (sel == 11)
                window = 65535;
            else if (sel < 5)
                window = $urandom_range(6, 24);
            else
                window = $urandom_range(25, 200);
            en = (window != 65535) && ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 7) == 0)
                rate = 16'($urandom_range(0, 48000));
            else
                rate = 16'(TEMPLATE_CHOICES[$urandom_range(0, 6)]);
            set_config(en, rate, 16'(window));
            idle_on = ($urandom_range(0, 3) != 0);
            searches = $urandom_range(3, 8);
            repeat (searches)
            begin
                if (sent_bytes < RANDOM_BYTES)
                begin
                    if (window < 5)
                        len = $urandom_range(1, 4);
                    else if (window == 65535)
                        len = $urandom_range(4, 40);
                    else if ($urandom_range(0, 1) == 0)
                        len = window - 1 + $urandom_range(0, 3);
                    else
                        len = $urandom_range(1, window + 3);
                    run_search(len, (window == 65535) || ($urandom_range(0, 3) != 0),
                               (window == 65535) || ($urandom_range(0, 3) != 0));
                end
            end
            wait_drained();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_after_reset();
        test_tiny_window();
        test_window_exhausted();
        test_header_rejects();
        test_input_backpressure();
        test_random_streams();
        wait_drained();
        if (error_count == 0)
            $display("[mpeg_audio_header_scanner_unit] OK");
        else
            $display("[mpeg_audio_header_scanner_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[mpeg_audio_header_scanner_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/mahs_pkg.sv
sv/mahs_front.sv
sv/mahs_queue.sv
sv/mahs_back.sv
sv/mpeg_audio_header_scanner_unit.sv
dv/mpeg_audio_header_scanner_unit_test.sv
